/* rtl/ypt_pkg.sv */
`default_nettype none

package ypt_pkg;

    // CORDIC works on Q30 values with two guard bits above the sign
    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_W      = 34;
    localparam int CORDIC_FRAC   = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // translated point: exact difference of two 32-bit values
    localparam int VEC_W = 33;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_YAW      = 3'd0,
        REG_PITCH    = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_OFFSET_Y = 3'd3,
        REG_OFFSET_Z = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_req_t;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
    } point_res_t;

    typedef struct packed {
        logic                  local_mode;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } vec_item_t;

    function automatic logic signed [CORDIC_W-1:0] cordic_atan(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] val;
        unique case (idx)
            5'd0:    val = 34'sd536870912;
            5'd1:    val = 34'sd316933406;
            5'd2:    val = 34'sd167458907;
            5'd3:    val = 34'sd85004756;
            5'd4:    val = 34'sd42667331;
            5'd5:    val = 34'sd21354465;
            5'd6:    val = 34'sd10679838;
            5'd7:    val = 34'sd5340245;
            5'd8:    val = 34'sd2670163;
            5'd9:    val = 34'sd1335087;
            5'd10:   val = 34'sd667544;
            5'd11:   val = 34'sd333772;
            5'd12:   val = 34'sd166886;
            5'd13:   val = 34'sd83443;
            5'd14:   val = 34'sd41722;
            5'd15:   val = 34'sd20861;
            5'd16:   val = 34'sd10430;
            5'd17:   val = 34'sd5215;
            5'd18:   val = 34'sd2608;
            5'd19:   val = 34'sd1304;
            5'd20:   val = 34'sd652;
            5'd21:   val = 34'sd326;
            5'd22:   val = 34'sd163;
            5'd23:   val = 34'sd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* rtl/yaw_pitch_point_transform.sv */
`default_nettype none

// Channel    Direction  Handshake              Payload
// s_         in         s_valid / s_ready      point_req_t: opcode, point_x/y/z
// m_         out        m_valid / m_ready      point_res_t: result_x/y/z
// cfg_       in         cfg_valid / cfg_ready  cfg_index (register), cfg_data
//
// One point per cycle sustained while m_ready is high and no rebuild runs; a point
// passes the queue, multiply stage, sum and round stage, offset and clamp register.
// Writing a yaw or pitch angle, and leaving reset, rebuilds both rotation bases in a
// shared CORDIC sequencer: 4 angles, each loaded, iterated and stored, then 8 basis
// products, all with s_ready low. Reset is synchronous and active low.
// A stalled m_ stage freezes the back pipe; the 4-entry queue keeps s_ready up until
// it fills.
module yaw_pitch_point_transform #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ypt_pkg::point_req_t s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ypt_pkg::point_res_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    logic [15:0]        yaw_reg;
    logic [15:0]        pitch_reg;
    logic signed [31:0] offset_x_reg;
    logic signed [31:0] offset_y_reg;
    logic signed [31:0] offset_z_reg;

    logic cfg_write;
    logic trig_start;
    logic basis_busy;
    logic [1:0][2:0][2:0][TRIG_FRAC_BITS+1:0] basis;

    logic               q_push, q_full, q_pop, q_empty;
    ypt_pkg::vec_item_t q_in_item, q_out_item;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign trig_start = cfg_write && (cfg_index == ypt_pkg::REG_YAW ||
                                      cfg_index == ypt_pkg::REG_PITCH);

    // drop writes beyond the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                ypt_pkg::REG_YAW:      yaw_reg      <= cfg_data[15:0];
                ypt_pkg::REG_PITCH:    pitch_reg    <= cfg_data[15:0];
                ypt_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data;
                ypt_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data;
                ypt_pkg::REG_OFFSET_Z: offset_z_reg <= cfg_data;
                default:               yaw_reg      <= yaw_reg;
            endcase
        end
    end

    ypt_trig #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_trig (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (trig_start),
        .yaw_angle   (yaw_reg),
        .pitch_angle (pitch_reg),
        .busy        (basis_busy),
        .basis       (basis)
    );

    ypt_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .basis_busy (basis_busy),
        .queue_full (q_full),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .offset_z   (offset_z_reg),
        .push       (q_push),
        .item       (q_in_item)
    );

    ypt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    ypt_back #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (!q_empty),
        .item       (q_out_item),
        .pop        (q_pop),
        .basis      (basis),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .offset_z   (offset_z_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

/* rtl/ypt_trig.sv */
`default_nettype none

module ypt_trig #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] yaw_angle,
    input  wire logic [15:0] pitch_angle,
    output logic             busy,
    output logic [1:0][2:0][2:0][TRIG_FRAC_BITS+1:0] basis
);

    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int CW     = ypt_pkg::CORDIC_W;
    localparam int STEP_W = $clog2(ypt_pkg::CORDIC_STAGES);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(ypt_pkg::CORDIC_STAGES - 1);
    localparam logic [1:0]        LAST_ANGLE = 2'd3;
    localparam logic [2:0]        LAST_PROD  = 3'd7;
    localparam logic signed [CW-1:0] TRIG_RND =
        CW'(1) << (ypt_pkg::CORDIC_FRAC - TRIG_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] TRIG_ONE = CW'(1) << TRIG_FRAC_BITS;
    localparam logic signed [2*TW-1:0] PROD_RND = (2*TW)'(1) << (TRIG_FRAC_BITS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ITER  = 5'b00100,
        ST_STORE = 5'b01000,
        ST_PROD  = 5'b10000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [1:0]        angle_sel_reg, angle_sel_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        prod_sel_reg, prod_sel_next;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic                 flip_reg;
    logic signed [TW-1:0] sin_reg [4];
    logic signed [TW-1:0] cos_reg [4];
    logic signed [TW-1:0] prod_reg [8];

    logic [15:0]          cur_angle;
    logic                 flip;
    logic signed [CW-1:0] z_init;
    logic signed [CW-1:0] dx, dy, atan_val;
    logic signed [CW-1:0] x_fin, y_fin;
    logic signed [TW-1:0] op_a, op_b;
    logic signed [2*TW-1:0] prod_full, prod_rnd;
    logic signed [TW-1:0] prod_val;

    function automatic logic signed [TW-1:0] to_trig(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + TRIG_RND) >>> (ypt_pkg::CORDIC_FRAC - TRIG_FRAC_BITS);
        if (r > TRIG_ONE) begin
            r = TRIG_ONE;
        end else if (r < -TRIG_ONE) begin
            r = -TRIG_ONE;
        end
        return TW'(r);
    endfunction

    // angles in order: yaw, pitch, negated yaw, negated pitch
    always_comb begin
        unique case (angle_sel_reg)
            2'd0:    cur_angle = yaw_angle;
            2'd1:    cur_angle = pitch_angle;
            2'd2:    cur_angle = 16'h0000 - yaw_angle;
            default: cur_angle = 16'h0000 - pitch_angle;
        endcase
    end

    // fold the second and third quadrants by half a turn
    assign flip   = cur_angle[15] ^ cur_angle[14];
    assign z_init = CW'($signed({cur_angle[15] ^ flip, cur_angle[14:0], 16'h0000}));

    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = ypt_pkg::cordic_atan(5'(step_reg));
    assign x_fin    = flip_reg ? -x_reg : x_reg;
    assign y_fin    = flip_reg ? -y_reg : y_reg;

    // product order per basis: sy*sp, cy*sp, sy*cp, cy*cp
    always_comb begin
        if (prod_sel_reg[2]) begin
            op_a = prod_sel_reg[0] ? cos_reg[2] : sin_reg[2];
            op_b = prod_sel_reg[1] ? cos_reg[3] : sin_reg[3];
        end else begin
            op_a = prod_sel_reg[0] ? cos_reg[0] : sin_reg[0];
            op_b = prod_sel_reg[1] ? cos_reg[1] : sin_reg[1];
        end
    end

    assign prod_full = op_a * op_b;
    assign prod_rnd  = (prod_full + PROD_RND) >>> TRIG_FRAC_BITS;
    // cy*sp and sy*cp enter the basis negated
    assign prod_val  = (prod_sel_reg[0] ^ prod_sel_reg[1]) ? -TW'(prod_rnd) : TW'(prod_rnd);

    always_comb begin
        state_next     = state_reg;
        angle_sel_next = angle_sel_reg;
        step_next      = step_reg;
        prod_sel_next  = prod_sel_reg;
        if (start) begin
            state_next     = ST_LOAD;
            angle_sel_next = '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    state_next = ST_IDLE;
                end
                ST_LOAD: begin
                    state_next = ST_ITER;
                    step_next  = '0;
                end
                ST_ITER: begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_STEP) begin
                        state_next = ST_STORE;
                    end
                end
                ST_STORE: begin
                    if (angle_sel_reg == LAST_ANGLE) begin
                        state_next    = ST_PROD;
                        prod_sel_next = '0;
                    end else begin
                        angle_sel_next = angle_sel_reg + 1'b1;
                        state_next     = ST_LOAD;
                    end
                end
                ST_PROD: begin
                    prod_sel_next = prod_sel_reg + 1'b1;
                    if (prod_sel_reg == LAST_PROD) begin
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // rebuild both bases straight out of reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            angle_sel_reg <= '0;
            step_reg      <= '0;
            prod_sel_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            angle_sel_reg <= angle_sel_next;
            step_reg      <= step_next;
            prod_sel_reg  <= prod_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            x_reg    <= ypt_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip;
        end else if (state_reg == ST_ITER) begin
            if (!z_reg[CW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_val;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_val;
            end
        end else if (state_reg == ST_STORE) begin
            cos_reg[angle_sel_reg] <= to_trig(x_fin);
            sin_reg[angle_sel_reg] <= to_trig(y_fin);
        end else if (state_reg == ST_PROD) begin
            prod_reg[prod_sel_reg] <= prod_val;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // basis[mode][out][in]: i = (cy,0,sy), j = (sy*sp,cp,-cy*sp), k = (-sy*cp,sp,cy*cp)
    always_comb begin
        basis[0][0][0] = cos_reg[0];
        basis[0][0][1] = prod_reg[0];
        basis[0][0][2] = prod_reg[2];
        basis[0][1][0] = '0;
        basis[0][1][1] = cos_reg[1];
        basis[0][1][2] = sin_reg[1];
        basis[0][2][0] = sin_reg[0];
        basis[0][2][1] = prod_reg[1];
        basis[0][2][2] = prod_reg[3];
        basis[1][0][0] = cos_reg[2];
        basis[1][0][1] = prod_reg[4];
        basis[1][0][2] = prod_reg[6];
        basis[1][1][0] = '0;
        basis[1][1][1] = cos_reg[3];
        basis[1][1][2] = sin_reg[3];
        basis[1][2][0] = sin_reg[2];
        basis[1][2][1] = prod_reg[5];
        basis[1][2][2] = prod_reg[7];
    end

endmodule

`default_nettype wire

/* rtl/ypt_front.sv */
`default_nettype none

module ypt_front (
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ypt_pkg::point_req_t s_data,
    input  wire logic                basis_busy,
    input  wire logic                queue_full,
    input  wire logic signed [31:0]  offset_x,
    input  wire logic signed [31:0]  offset_y,
    input  wire logic signed [31:0]  offset_z,
    output logic                     push,
    output ypt_pkg::vec_item_t       item
);

    localparam int VW = ypt_pkg::VEC_W;

    // hold requests while the basis is being rebuilt
    assign s_ready = !basis_busy && !queue_full;
    assign push    = s_valid && s_ready;

    // local mode translates before rotating; keep the difference exact
    always_comb begin
        item.local_mode = s_data.opcode;
        if (s_data.opcode) begin
            item.vec_x = VW'(s_data.point_x) - VW'(offset_x);
            item.vec_y = VW'(s_data.point_y) - VW'(offset_y);
            item.vec_z = VW'(s_data.point_z) - VW'(offset_z);
        end else begin
            item.vec_x = VW'(s_data.point_x);
            item.vec_y = VW'(s_data.point_y);
            item.vec_z = VW'(s_data.point_z);
        end
    end

endmodule

`default_nettype wire

/* rtl/ypt_queue.sv */
`default_nettype none

module ypt_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire ypt_pkg::vec_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output ypt_pkg::vec_item_t      pop_item,
    output logic                    empty
);

    localparam int DEPTH = ypt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    ypt_pkg::vec_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/ypt_back.sv */
`default_nettype none

module ypt_back #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_valid,
    input  wire ypt_pkg::vec_item_t  item,
    output logic                     pop,
    input  wire logic [1:0][2:0][2:0][TRIG_FRAC_BITS+1:0] basis,
    input  wire logic signed [31:0]  offset_x,
    input  wire logic signed [31:0]  offset_y,
    input  wire logic signed [31:0]  offset_z,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ypt_pkg::point_res_t      m_data
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int VW = ypt_pkg::VEC_W;
    localparam int PW = VW + TW;
    localparam int SW = PW + 2;
    localparam int RW = SW - TRIG_FRAC_BITS;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    logic advance;

    logic [2:0][2:0][TW-1:0] bsel;
    logic signed [VW-1:0]    vin [3];
    logic signed [PW-1:0]    prod_next [3][3];
    logic signed [PW-1:0]    s1_prod_reg [3][3];
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_mode_reg;

    logic signed [SW-1:0]    sum [3];
    logic signed [RW-1:0]    rot_next [3];
    logic signed [RW-1:0]    s2_rot_reg [3];
    logic                    s2_valid_reg, s2_valid_next;
    logic                    s2_mode_reg;

    logic signed [31:0]      off [3];
    logic signed [RW:0]      tot [3];
    logic [RW-31:0]          tot_hi [3];
    logic [31:0]             res [3];
    logic                    m_valid_reg, m_valid_next;
    ypt_pkg::point_res_t     m_data_reg, m_data_next;

    // the whole pipe moves when the output register is free or being drained
    assign advance = !m_valid_reg || m_ready;
    assign pop     = advance && item_valid;

    assign bsel   = item.local_mode ? basis[1] : basis[0];
    assign vin[0] = item.vec_x;
    assign vin[1] = item.vec_y;
    assign vin[2] = item.vec_z;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[n][c] = vin[c] * $signed(bsel[n][c]);
            end
        end
    end

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            sum[n] = SW'(s1_prod_reg[n][0]) + SW'(s1_prod_reg[n][1])
                   + SW'(s1_prod_reg[n][2]) + ROUND_HALF;
            rot_next[n] = RW'(sum[n] >>> TRIG_FRAC_BITS);
        end
    end

    assign off[0] = offset_x;
    assign off[1] = offset_y;
    assign off[2] = offset_z;

    // world mode adds the offset after rotation, then clamp to 32 bits
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            if (s2_mode_reg) begin
                tot[n] = (RW+1)'(s2_rot_reg[n]);
            end else begin
                tot[n] = (RW+1)'(s2_rot_reg[n]) + (RW+1)'(off[n]);
            end
            tot_hi[n] = tot[n][RW:31];
            if (tot_hi[n] == '0 || tot_hi[n] == '1) begin
                res[n] = tot[n][31:0];
            end else begin
                res[n] = tot[n][RW] ? SAT_MIN : SAT_MAX;
            end
        end
        m_data_next.result_x = res[0];
        m_data_next.result_y = res[1];
        m_data_next.result_z = res[2];
    end

    assign s1_valid_next = advance ? item_valid : s1_valid_reg;
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;
    assign m_valid_next  = advance ? s2_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_prod_reg <= prod_next;
            s1_mode_reg <= item.local_mode;
            s2_rot_reg  <= rot_next;
            s2_mode_reg <= s1_mode_reg;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
